[src/assert_macros.svh]
// Shared assertion macros for the arc cosine unit checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising clock edge outside reset.
`define ACOS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("acos check failed");

// Implication from a condition to a consequence on the same edge.
`define ACOS_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("acos check failed");

`endif

[src/acos_pkg.sv]
package acos_pkg;

  // Fixed-point scale points.
  localparam int unsigned OneQ14    = 16384;
  localparam int unsigned HalfQ14   = 8192;
  localparam int unsigned PiQ16     = 205887;
  localparam int unsigned HalfPiQ16 = 102944;

  // Horner coefficients in unsigned Q30.
  localparam logic [30:0] Coef3 = 31'd20110433;
  localparam logic [30:0] Coef2 = 31'd79737142;
  localparam logic [30:0] Coef1 = 31'd227756103;
  localparam logic [30:0] Coef0 = 31'd1686557207;

  localparam int unsigned HornerStages = 3;
  localparam logic [30:0] HornerCoef [HornerStages] = '{Coef2, Coef1, Coef0};

  // Square root: one result bit per step, three steps per pipeline stage.
  localparam int unsigned SqrtIters     = 17;
  localparam int unsigned StepsPerStage = 3;
  localparam int unsigned SqrtStages    = (SqrtIters + StepsPerStage - 1) / StepsPerStage;

  // Edges from request to the edge that takes the result.
  localparam int unsigned PipeLatency = SqrtStages + 3;

  // Payload of one square root / Horner pipeline stage.
  typedef struct packed {
    logic        neg;
    logic [14:0] mag;
    logic [30:0] poly;
    logic [32:0] rem;
    logic [33:0] res;
  } acos_stage_t;

endpackage

[src/arc_cosine_polynomial_approximation_top.sv]
// Channel   | Direction | Handshake             | Payload
// ----------+-----------+-----------------------+-------------------------------
// request   | in        | start_i, busy_o       | cosine_value_i (signed Q14)
// result    | out       | done_o (strobe)       | angle_radians_o (unsigned Q16)
//
// One request is taken every cycle; busy_o stays low since the pipeline never stalls.
// Each request passes an input stage, six square root stages (17 root bits at
// three per stage, Horner steps in the first three), a product stage and the
// output register.
// rst_ni clears all valid bits asynchronously; data registers are not reset.
// Results are strobed for one cycle and the receiver cannot hold them off.
module arc_cosine_polynomial_approximation_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [15:0] cosine_value_i,
  output logic               done_o,
  output logic [17:0]        angle_radians_o
);
  import acos_pkg::*;

  acos_stage_t stage_d [SqrtStages+1];
  acos_stage_t stage_q [SqrtStages+1];
  logic        vld_q   [SqrtStages+1];

  logic [47:0] prod_d, prod_q;
  logic        prod_neg_q;
  logic        prod_vld_q;

  logic [17:0] angle_d, angle_q;
  logic        done_q;

  logic [15:0] mag_in;
  logic [14:0] mag_clamp;
  logic [14:0] dist_one;

  // The pipeline always takes a new request.
  assign busy_o = 1'b0;

  // Input stage: magnitude, clamp to one, and the square root radicand.
  always_comb begin
    mag_in    = cosine_value_i[15] ? (16'd0 - cosine_value_i) : cosine_value_i;
    mag_clamp = (mag_in > 16'(OneQ14)) ? 15'(OneQ14) : mag_in[14:0];
    dist_one  = 15'(OneQ14) - mag_clamp;
  end

  // Input stage payload, then the square root and Horner stages.
  always_comb begin
    logic [45:0] hprod;
    logic [30:0] hrnd;
    logic [33:0] bitv;
    logic [33:0] trial;
    stage_d[0].neg  = cosine_value_i[15];
    stage_d[0].mag  = mag_clamp;
    stage_d[0].poly = Coef3;
    stage_d[0].rem  = {dist_one, 18'd0};
    stage_d[0].res  = '0;
    for (int k = 1; k <= SqrtStages; k++) begin
      stage_d[k] = stage_q[k-1];
      if (k <= HornerStages) begin
        hprod = 46'(stage_q[k-1].mag) * 46'(stage_q[k-1].poly);
        hprod = hprod + 46'(HalfQ14);
        hrnd  = hprod[44:14];
        stage_d[k].poly = HornerCoef[k-1] - hrnd;
      end
      for (int j = 0; j < StepsPerStage; j++) begin
        if ((k - 1) * StepsPerStage + j < SqrtIters) begin
          bitv  = 34'(1) << (2 * (SqrtIters - 1) - 2 * ((k - 1) * StepsPerStage + j));
          trial = stage_d[k].res + bitv;
          if ({1'b0, stage_d[k].rem} >= trial) begin
            stage_d[k].rem = 33'({1'b0, stage_d[k].rem} - trial);
            stage_d[k].res = (stage_d[k].res >> 1) + bitv;
          end else begin
            stage_d[k].res = stage_d[k].res >> 1;
          end
        end
      end
    end
  end

  // Product of the polynomial and the root.
  assign prod_d = 48'(stage_q[SqrtStages].poly) * 48'(stage_q[SqrtStages].res[16:0]);

  // Rounding, saturation at pi and reflection for negative inputs.
  always_comb begin
    logic [47:0] sum;
    logic [17:0] v;
    sum = prod_q + (48'(1) << 29);
    v   = sum[47:30];
    if (v > 18'(PiQ16)) begin
      v = 18'(PiQ16);
    end
    angle_d = prod_neg_q ? (18'(PiQ16) - v) : v;
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= SqrtStages; k++) begin
        vld_q[k] <= 1'b0;
      end
      prod_vld_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      vld_q[0] <= start_i && !busy_o;
      for (int k = 1; k <= SqrtStages; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
      prod_vld_q <= vld_q[SqrtStages];
      done_q     <= prod_vld_q;
    end
  end

  // Data registers.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= SqrtStages; k++) begin
      stage_q[k] <= stage_d[k];
    end
    prod_q     <= prod_d;
    prod_neg_q <= stage_q[SqrtStages].neg;
    angle_q    <= angle_d;
  end

  assign done_o          = done_q;
  assign angle_radians_o = angle_q;

endmodule

[src/acos_chk.sv]
`include "assert_macros.svh"

module acos_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic signed [15:0] cosine_value_i,
  input logic               done_o,
  input logic [17:0]        angle_radians_o
);
  import acos_pkg::*;

  // A result only follows a request taken the fixed latency earlier.
  `ACOS_ASSERT_IMP(a_done_has_request, clk_i, rst_ni, done_o, $past(start_i && !busy_o, PipeLatency))

  // The angle never passes pi.
  `ACOS_ASSERT_IMP(a_angle_range, clk_i, rst_ni, done_o, angle_radians_o <= 18'(PiQ16))

  // Non-negative cosines land at or below a right angle, negative ones at or above.
  `ACOS_ASSERT_IMP(a_angle_half, clk_i, rst_ni, done_o, $past(cosine_value_i[15], PipeLatency) ? (angle_radians_o >= 18'(HalfPiQ16)) : (angle_radians_o <= 18'(HalfPiQ16)))

  // A cosine of exactly one gives a zero angle.
  `ACOS_ASSERT_IMP(a_angle_zero, clk_i, rst_ni, done_o && ($past(cosine_value_i, PipeLatency) == 16'sd16384), angle_radians_o == 18'd0)

endmodule

bind arc_cosine_polynomial_approximation_top acos_chk u_acos_chk (.*);

[tb/angle_checker.sv]
// Watches the request and result channels of the arc cosine unit, predicts
// every angle and compares the results in order.
module angle_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic signed [15:0] cosine_value_i,
  input  logic               done_i,
  input  logic [17:0]        angle_radians_i,
  output int                 pending_o,
  output int                 fail_count_o
);
  import acos_pkg::*;

  // Angles predicted for accepted requests, oldest first.
  logic [17:0] expected_angles [$];
  int          mismatches = 0;

  // Integer square root, rounded down, one result bit per step.
  function automatic logic [63:0] isqrt_floor(input logic [63:0] radicand);
    logic [63:0] n;
    logic [63:0] root;
    logic [63:0] bit_pos;
    n       = radicand;
    root    = 64'd0;
    bit_pos = 64'd1 << 62;
    while (bit_pos > n) bit_pos = bit_pos >> 2;
    while (bit_pos != 64'd0) begin
      if (n >= root + bit_pos) begin
        n    = n - (root + bit_pos);
        root = (root >> 1) + bit_pos;
      end else begin
        root = root >> 1;
      end
      bit_pos = bit_pos >> 2;
    end
    return root;
  endfunction

  // Expected angle in unsigned Q16 for a signed Q14 cosine.
  function automatic logic [17:0] predict_angle(input logic signed [15:0] cosine);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] horner;
    logic [63:0] root;
    logic [63:0] prod;
    logic [63:0] angle;
    neg = cosine[15];
    mag = neg ? (64'h10000 - {48'd0, cosine}) : {48'd0, cosine};
    // Magnitudes beyond one, the most negative code too, clamp to one.
    if (mag > OneQ14) mag = OneQ14;

    // Horner's rule in Q30 with each product rounded to nearest.
    horner = Coef2 - ((mag * Coef3 + HalfQ14) >> 14);
    horner = Coef1 - ((mag * horner + HalfQ14) >> 14);
    horner = Coef0 - ((mag * horner + HalfQ14) >> 14);

    root = isqrt_floor((OneQ14 - mag) << 18);
    prod = (horner * root + (64'd1 << 29)) >> 30;
    if (prod > PiQ16) prod = PiQ16;

    // Negative cosines reflect to pi minus the angle, then saturate at pi.
    angle = neg ? (PiQ16 - prod) : prod;
    if (angle > PiQ16) angle = PiQ16;
    return angle[17:0];
  endfunction

  // Results are taken before requests: a result never belongs to a request
  // accepted on the same edge.
  always @(posedge clk_i) begin : check_edge
    logic [17:0] want;
    if (rst_ni) begin
      if (done_i) begin
        if (expected_angles.size() == 0) begin
          if (mismatches < 10) begin
            $display("angle_checker: result %0d with no request waiting", angle_radians_i);
          end
          mismatches++;
        end else begin
          want = expected_angles.pop_front();
          if (angle_radians_i !== want) begin
            if (mismatches < 10) begin
              $display("angle_checker: angle_radians expected %0d, got %0d", want,
                       angle_radians_i);
            end
            mismatches++;
          end
        end
      end
      if (start_i && !busy_i) begin
        expected_angles.push_back(predict_angle(cosine_value_i));
      end
      pending_o    <= expected_angles.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

[tb/testbench.sv]
// Drives cosine requests into the arc cosine unit and gives the verdict.
module testbench;
  import acos_pkg::*;

  localparam int CycleLimit   = 300000;
  localparam int RandomItems  = 1550;
  localparam int PhaseCount   = 4;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic signed [15:0] cosine_value_i = 16'sd0;
  logic               busy_o;
  logic               done_o;
  logic [17:0]        angle_radians_o;
  int                 pending;
  int                 fail_count;

  // Percentage of cycles in which the sender holds its request back.
  int idle_pct = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  arc_cosine_polynomial_approximation_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .cosine_value_i  (cosine_value_i),
    .done_o          (done_o),
    .angle_radians_o (angle_radians_o)
  );

  angle_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_i          (busy_o),
    .cosine_value_i  (cosine_value_i),
    .done_i          (done_o),
    .angle_radians_i (angle_radians_o),
    .pending_o       (pending),
    .fail_count_o    (fail_count)
  );

  // Offers one request, with random idle cycles first, and returns once it
  // has been taken.
  task automatic send_cosine(input logic signed [15:0] cosine);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i        <= 1'b1;
    cosine_value_i <= cosine;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Drops the request line and waits until every predicted angle has come.
  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Mostly legal cosines, some hugging plus or minus one, the rest any code.
  function automatic logic signed [15:0] random_cosine();
    int pick;
    int value;
    pick = $urandom_range(99);
    if (pick < 75) begin
      value = int'($urandom_range(32768)) - 16384;
    end else if (pick < 88) begin
      value = 16384 - int'($urandom_range(24));
      if ($urandom_range(1) == 1) value = -value;
    end else begin
      value = int'($urandom_range(65535));
    end
    return value[15:0];
  endfunction

  // Corner cosines: both ends, zero, codes just past one, the most negative
  // code, alternating bit patterns and a few interior points.
  logic signed [15:0] corner_cosines [] = '{
    16'sd16384, -16'sd16384, 16'sd0, 16'sd1, -16'sd1, 16'sd16383, -16'sd16383,
    16'sd16385, -16'sd16385, 16'sd32767, -16'sd32767, -16'sd32768, 16'sd8192,
    -16'sd8192, 16'sd11585, -16'sd11585, 16'sh5555, 16'shAAAA, 16'sd2, -16'sd2,
    16'sd100, -16'sd100
  };

  int phase_pct [PhaseCount] = '{0, 76, 0, 17};

  // Request stream: corners back to back, a full drain, then random phases.
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_cosines[i]) send_cosine(corner_cosines[i]);
    drain_results();

    for (int phase = 0; phase < PhaseCount; phase++) begin
      idle_pct = phase_pct[phase];
      for (int n = 0; n < RandomItems / PhaseCount; n++) send_cosine(random_cosine());
    end
    drain_results();
    repeat (PipeLatency + 4) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Ends a hung run.
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("testbench: errors");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/acos_pkg.sv
src/arc_cosine_polynomial_approximation_top.sv
src/acos_chk.sv
tb/angle_checker.sv
tb/testbench.sv
